// ----- hw/rtl/glc_pkg.sv -----
// shared types and constants for the glyph lru slot cache
// no dependencies
package glc_pkg;

    localparam int SLOTS_DEF = 256;
    localparam logic [8:0] SUI_RESET = 9'd256;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic clear_all;
        logic clear_marks;
        logic upd;
        logic age_all;
        logic write_code;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/glc_cell.sv -----
// one cache slot: tag, recency rank and batch used mark
// depends on glc_pkg
module glc_cell #(
    parameter int IW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  glc_pkg::t_cell_ctl i_ctl,
    input  logic [20:0]      i_code,
    input  logic             i_valid_lk,
    input  logic             i_valid_up,
    input  logic             i_sel,
    input  logic [IW-1:0]    i_old_age,
    output logic             o_match,
    output logic [IW-1:0]    o_rec,
    output logic             o_mark
);
    import glc_pkg::*;

    logic [20:0]   r_code;
    logic [IW-1:0] r_rec;
    logic          r_mark;

    assign o_match = i_valid_lk && (r_code == i_code);
    assign o_rec   = r_rec;
    assign o_mark  = r_mark;

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_sel && i_ctl.write_code) begin
            r_code <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_all) begin
            r_rec  <= '0;
            r_mark <= 1'b0;
        end else begin
            if (i_ctl.upd) begin
                if (i_sel) begin
                    r_rec <= '0;
                end else if (i_valid_up && (i_ctl.age_all || r_rec < i_old_age)) begin
                    r_rec <= r_rec + 1'b1;
                end
            end
            if (i_ctl.clear_marks) begin
                r_mark <= 1'b0;
            end else if (i_ctl.upd && i_sel) begin
                r_mark <= 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/glyph_lru_slot_cache_core.sv -----
// a lookup passes the look and update states, then the result register; a
// flush goes straight to it; one flush per cycle unless the output stalls;
// one lookup at a time: tag compare, then recency update across all cells
// reset (synchronous, active low): cache empty, 256 slots in use, marks clear
// a write of slots_in_use empties the cache
module glyph_lru_slot_cache_core #(
    parameter int SLOTS = glc_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [20:0] i_code_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_slot,
    output logic        o_miss,
    output logic        o_evicted,
    output logic        o_flush_request
);
    import glc_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    function automatic logic [CW-1:0] f_cap(input logic [8:0] v);
        if (v == 9'd0) return CW'(1);
        if (int'(v) > SLOTS) return CW'(SLOTS);
        return CW'(v);
    endfunction

    t_state r_state, n_state;
    logic [8:0]    r_sui;
    logic [CW-1:0] r_free, r_cnt;
    logic          r_cmd;
    logic [20:0]   r_code;
    logic [IW-1:0] r_slot, r_old;
    logic          r_miss, r_evict, r_age_all;
    logic          r_ovalid;
    logic [7:0]    r_oslot;
    logic          r_omiss, r_oevict, r_oflush;

    logic [CW-1:0] w_cap;
    logic          w_accept;
    t_cell_ctl     w_ctl;
    logic [SLOTS-1:0] w_match, w_evm, w_mark, w_sel, w_vlk, w_vup;
    logic [IW-1:0] w_rec [SLOTS];
    logic [IW-1:0] w_hit_idx, w_hit_age, w_ev_idx, w_cap_m1;
    logic          w_hit, w_mark_sel, w_flush;
    logic [CW-1:0] w_cnt_n;
    logic [IW+7:0] w_slot_ext;

    assign w_cap    = f_cap(r_sui);
    assign w_cap_m1 = IW'(w_cap - 1'b1);
    assign o_stall  = !((r_state == ST_IDLE) && (!r_ovalid || !i_stall));
    assign w_accept = i_valid && !o_stall;

    // per-cell window and selection
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_vlk[i] = (CW'(i) >= r_free) && (CW'(i) < w_cap);
            w_vup[i] = w_vlk[i];
            w_sel[i] = (IW'(i) == r_slot);
            w_evm[i] = (CW'(i) < w_cap) && (w_rec[i] == w_cap_m1);
        end
    end

    // one-hot to index reductions
    always_comb begin
        w_hit_idx  = '0;
        w_hit_age  = '0;
        w_ev_idx   = '0;
        w_mark_sel = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
                w_hit_age = w_hit_age | w_rec[i];
            end
            if (w_evm[i]) w_ev_idx = w_ev_idx | IW'(i);
            w_mark_sel = w_mark_sel | (w_mark[i] & w_sel[i]);
        end
    end
    assign w_hit   = |w_match;
    assign w_cnt_n = r_cnt + CW'(!w_mark_sel);
    assign w_flush = (w_cnt_n >= w_cap);

    always_comb begin
        n_state           = r_state;
        w_ctl             = '0;
        w_ctl.clear_all   = i_cfg_we;
        w_ctl.age_all     = r_age_all;
        w_ctl.write_code  = r_miss;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_FLUSH) w_ctl.clear_marks = 1'b1;
                    else n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_UPD;
            ST_UPD: begin
                w_ctl.upd         = 1'b1;
                w_ctl.clear_marks = w_flush;
                n_state           = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        glc_cell #(.IW(IW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_code     (r_code),
            .i_valid_lk (w_vlk[g]),
            .i_valid_up (w_vup[g]),
            .i_sel      (w_sel[g]),
            .i_old_age  (r_old),
            .o_match    (w_match[g]),
            .o_rec      (w_rec[g]),
            .o_mark     (w_mark[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_code <= i_code_point;
        end
        if (r_state == ST_LOOK) begin
            r_miss    <= !w_hit;
            r_evict   <= !w_hit && (r_free == '0);
            r_age_all <= !w_hit && (r_free != '0);
            if (w_hit) begin
                r_slot <= w_hit_idx;
                r_old  <= w_hit_age;
            end else if (r_free != '0) begin
                r_slot <= IW'(r_free - 1'b1);
                r_old  <= w_cap_m1;
            end else begin
                r_slot <= w_ev_idx;
                r_old  <= w_cap_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sui  <= SUI_RESET;
            r_free <= f_cap(SUI_RESET);
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_sui  <= i_cfg_data;
            r_free <= f_cap(i_cfg_data);
            r_cnt  <= '0;
        end else begin
            if (w_accept && i_command == CMD_FLUSH) r_cnt <= '0;
            if (r_state == ST_LOOK && !w_hit && r_free != '0) r_free <= r_free - 1'b1;
            if (r_state == ST_UPD) r_cnt <= w_flush ? '0 : w_cnt_n;
        end
    end

    assign w_slot_ext = {8'd0, r_slot};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_accept && i_command == CMD_FLUSH) begin
            r_ovalid <= 1'b1;
        end else if (r_state == ST_UPD) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == CMD_FLUSH) begin
            r_oslot  <= 8'd0;
            r_omiss  <= 1'b0;
            r_oevict <= 1'b0;
            r_oflush <= 1'b0;
        end else if (r_state == ST_UPD) begin
            r_oslot  <= w_slot_ext[7:0];
            r_omiss  <= r_miss;
            r_oevict <= r_evict;
            r_oflush <= w_flush;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_slot          = r_oslot;
    assign o_miss          = r_omiss;
    assign o_evicted       = r_oevict;
    assign o_flush_request = r_oflush;

    a_free_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= w_cap) else $error("free count above capacity");
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |-> $onehot0(w_match)) else $error("tag held twice");
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && !w_hit && r_free == '0) |-> $onehot(w_evm))
        else $error("no unique lru slot");
    a_cnt_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_cnt < w_cap) else $error("batch count at capacity");
    a_cmd_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |-> r_cmd == CMD_LOOKUP) else $error("flush in lookup path");

endmodule
